// File: hdl/itoa_pkg.sv
// Shared constants, types and the digit character function for the radix ASCII converter.
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int WORD_WIDTH     = 32;
    localparam int DIGIT_BITS     = 4;
    localparam int STEP_BITS      = 4;
    localparam int DIV_STEPS      = WORD_WIDTH / STEP_BITS;
    localparam int STEP_CNT_BITS  = $clog2(DIV_STEPS);
    localparam int COUNT_BITS     = $clog2(WORD_WIDTH + 1);
    localparam int INDEX_BITS     = $clog2(WORD_WIDTH);
    localparam int RADIX_BITS     = 5;
    localparam int CHAR_BITS      = 7;
    localparam int S_TDATA_WIDTH  = 32;
    localparam int M_TDATA_WIDTH  = 8;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_INDEX_BITS = 1;

    localparam logic [RADIX_BITS-1:0]     RADIX_RESET   = 5'd10;
    localparam logic [RADIX_BITS-1:0]     RADIX_MIN     = 5'd2;
    localparam logic [RADIX_BITS-1:0]     RADIX_MAX     = 5'd16;
    localparam logic [RADIX_BITS-1:0]     RADIX_DECIMAL = 5'd10;
    localparam logic [CHAR_BITS-1:0]      CHAR_MINUS    = 7'h2D;
    localparam logic [CHAR_BITS-1:0]      CHAR_ZERO     = 7'h30;
    localparam logic [CHAR_BITS-1:0]      CHAR_ALPHA    = 7'h37;
    localparam logic [REG_INDEX_BITS-1:0] REG_RADIX     = 1'd0;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_ctl_t;

    // '0'..'9' then 'A'..'F'
    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ext;
        ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + ext;
        end
        return CHAR_ALPHA + ext;
    endfunction

endpackage

// File: hdl/itoa_div.sv
// Shared divider: divides a word by the radix, four quotient bits per cycle.
`timescale 1ns / 1ps

module itoa_div import itoa_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [WORD_WIDTH-1:0]  dividend,
    input  logic [RADIX_BITS-1:0]  divisor,
    output logic                   done,
    output logic [WORD_WIDTH-1:0]  quotient,
    output logic [DIGIT_BITS-1:0]  remainder
);

    logic [WORD_WIDTH-1:0]    work_reg, work_next;
    logic [DIGIT_BITS-1:0]    rem_reg, rem_next;
    logic [RADIX_BITS-1:0]    divisor_reg;
    logic [STEP_CNT_BITS-1:0] step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    // Restoring division, STEP_BITS dividend bits per cycle; quotient bits
    // shift in at the bottom while dividend bits leave at the top.
    always_comb begin
        logic [DIGIT_BITS:0] trial;
        logic [DIGIT_BITS:0] diff;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial     = {rem_next, work_next[WORD_WIDTH-1]};
            work_next = {work_next[WORD_WIDTH-2:0], 1'b0};
            diff      = trial - divisor_reg;
            if (trial >= divisor_reg) begin
                rem_next     = diff[DIGIT_BITS-1:0];
                work_next[0] = 1'b1;
            end else begin
                rem_next = trial[DIGIT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                step_reg    <= '0;
                work_reg    <= dividend;
                rem_reg     <= '0;
                divisor_reg <= divisor;
            end else if (busy_reg) begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_CNT_BITS'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/itoa_digit_stack.sv
// Digit stack: digits pushed least significant first, popped most significant first.
`timescale 1ns / 1ps

module itoa_digit_stack import itoa_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  stk_ctl_t               ctl,
    input  logic [DIGIT_BITS-1:0]  push_digit,
    output logic [COUNT_BITS-1:0]  count,
    output logic [DIGIT_BITS-1:0]  top_digit
);

    logic [DIGIT_BITS-1:0] mem_reg [WORD_WIDTH];
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] top_pos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.clear) begin
            count_reg <= '0;
        end else if (ctl.push) begin
            count_reg <= count_reg + 1'b1;
        end else if (ctl.pop) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push && !ctl.clear) begin
            mem_reg[count_reg[INDEX_BITS-1:0]] <= push_digit;
        end
    end

    assign top_pos   = count_reg - 1'b1;
    assign top_digit = mem_reg[top_pos[INDEX_BITS-1:0]];
    assign count     = count_reg;

endmodule

// File: hdl/integer_to_radix_ascii.sv
// Top level: radix register, conversion sequencer and output register.
`timescale 1ns / 1ps

// Converts one signed 32-bit integer per input transfer into ASCII digits in
// the radix held by the configuration register (2 to 16, reset value 10;
// written pwdata[4:0] below 2 acts as 2, above 16 as 16). Each output transfer
// carries one character, most significant digit first, with m_tlast on the
// final one. In radix 10 a negative value is preceded by '-'; other radixes
// print the raw two's-complement pattern.
// One shared divider produces each digit in 8 steps of four quotient bits,
// after which the sequencer takes the result. Once every digit is on the
// stack, one character leaves per cycle while the receiver keeps m_tready
// high. s_tready is high only between items; it returns high as soon as
// the last character sits in the output register, so the next item can
// start while that character waits. A stalled receiver holds the current
// character and pauses the character sequencer.
// Reset (aresetn low at a clock edge) drops any item in flight, clears
// m_tvalid and sets the radix to 10.

module integer_to_radix_ascii import itoa_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [APB_DATA_WIDTH-1:0]  pwdata,
    output logic [APB_DATA_WIDTH-1:0]  prdata,
    output logic                       pready,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [S_TDATA_WIDTH-1:0]   s_tdata,   // [31:0] value
    // output stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [M_TDATA_WIDTH-1:0]   m_tdata,   // [6:0] character, [7] zero
    output logic                       m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic                   minus_reg, minus_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CHAR_BITS-1:0]   char_reg, char_next;
    logic                   last_reg, last_next;
    logic [RADIX_BITS-1:0]  radix_reg;
    logic [RADIX_BITS-1:0]  radix_eff;

    logic                   accept;
    logic                   cfg_write;
    logic [REG_INDEX_BITS-1:0] reg_index;
    logic [WORD_WIDTH-1:0]  in_value;
    logic                   in_minus;
    logic [WORD_WIDTH-1:0]  in_mag;

    logic                   div_start;
    logic [WORD_WIDTH-1:0]  div_dividend;
    logic                   div_done;
    logic [WORD_WIDTH-1:0]  div_quot;
    logic [DIGIT_BITS-1:0]  div_rem;

    stk_ctl_t               stk_ctl;
    logic [COUNT_BITS-1:0]  stk_count;
    logic [DIGIT_BITS-1:0]  stk_top;
    logic                   out_free;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[APB_ADDR_WIDTH-1 -: REG_INDEX_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_write && reg_index == REG_RADIX) begin
            radix_reg <= pwdata[RADIX_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_RADIX) begin
            prdata = {{(APB_DATA_WIDTH-RADIX_BITS){1'b0}}, radix_reg};
        end
    end

    always_comb begin
        priority if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // input side
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_value = s_tdata[WORD_WIDTH-1:0];
    assign in_minus = in_value[WORD_WIDTH-1] && (radix_eff == RADIX_DECIMAL);
    assign in_mag   = in_minus ? (~in_value + 1'b1) : in_value;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        minus_next    = minus_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        char_next     = char_reg;
        last_next     = last_reg;
        div_start     = 1'b0;
        div_dividend  = in_mag;
        stk_ctl       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    minus_next    = in_minus;
                    div_start     = 1'b1;
                    stk_ctl.clear = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    stk_ctl.push = 1'b1;
                    if (div_quot == '0 || stk_count == COUNT_BITS'(WORD_WIDTH - 1)) begin
                        state_next = ST_EMIT;
                    end else begin
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (minus_reg) begin
                        char_next  = CHAR_MINUS;
                        last_next  = 1'b0;
                        minus_next = 1'b0;
                    end else begin
                        char_next   = digit_char(stk_top);
                        last_next   = (stk_count == COUNT_BITS'(1));
                        stk_ctl.pop = 1'b1;
                        if (stk_count == COUNT_BITS'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            minus_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            minus_reg    <= minus_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    itoa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (radix_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    itoa_digit_stack u_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (stk_ctl),
        .push_digit (div_rem),
        .count      (stk_count),
        .top_digit  (stk_top)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_WIDTH-CHAR_BITS){1'b0}}, char_reg};
    assign m_tlast  = last_reg;

endmodule

// File: hdl/itoa_checker.sv
// Port-level checks for the radix ASCII converter, bound to the top level.
`timescale 1ns / 1ps

module itoa_checker import itoa_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [M_TDATA_WIDTH-1:0]  m_tdata,
    input logic                      m_tlast
);

    // one item at a time: busy right after a transfer in
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a conversion is in progress");

    // a new item starts only once the previous string is down to its last character
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tlast))
        else $error("input taken before the previous string was complete");

    // a minus sign is never the end of a string
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[CHAR_BITS-1:0] == CHAR_MINUS |-> !m_tlast)
        else $error("minus sign flagged as last character");

    // stalled output holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: dv/integer_to_radix_ascii_tb.sv
// Self-checking testbench for the integer to radix ASCII converter.
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb import itoa_pkg::*; ;

    localparam int RX_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES   = 20;
    localparam int STALL_LIMIT    = 20000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 40;

    localparam logic [APB_ADDR_WIDTH-1:0] RADIX_ADDR    = {REG_RADIX, 2'b00};
    localparam logic [APB_ADDR_WIDTH-1:0] UNMAPPED_ADDR = 3'd4;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_BITS-1:0] ASCII_DASH    = 7'h2D;

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } ascii_char_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata;    // [31:0] value
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;    // [6:0] character, [7] zero
    logic                      m_tlast;

    ascii_char_t               pending_chars[$];
    logic [RADIX_BITS-1:0]     radix_setting = RADIX_RESET;
    int                        mismatch_count = 0;
    int                        stall_cycles = 0;
    bit                        tx_idle_on = 1'b1;
    bit                        rx_idle_on = 1'b1;
    bit                        rx_hold_req = 1'b0;

    integer_to_radix_ascii u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Expected characters of one value, most significant first.
    function automatic void queue_conversion(input logic [31:0] value);
        int unsigned          base;
        bit                   negative;
        logic [31:0]          mag;
        logic [3:0]           digit;
        logic [CHAR_BITS-1:0] chars[$];
        ascii_char_t          beat;

        if (radix_setting < RADIX_MIN) begin
            base = 2;
        end else if (radix_setting > RADIX_MAX) begin
            base = 16;
        end else begin
            base = 32'(radix_setting);
        end
        negative = value[31] && (base == 10);
        mag = negative ? (~value + 32'd1) : value;
        do begin
            digit = 4'(mag % base);
            if (digit < 4'd10) begin
                chars.push_front(ASCII_ZERO + 7'(digit));
            end else begin
                chars.push_front(ASCII_UPPER_A + 7'(digit - 4'd10));
            end
            mag = mag / base;
        end while (mag != 0);
        if (negative) begin
            chars.push_front(ASCII_DASH);
        end
        foreach (chars[i]) begin
            beat.character = chars[i];
            beat.last = (i == chars.size() - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(4))
            0, 1: return $urandom();
            2: return 32'($urandom_range(1000));
            3: return -32'($urandom_range(1000));
            default: return $urandom_range(1) ? 32'h8000_0000 + 32'($urandom_range(7))
                                              : 32'h7FFF_FFFF - 32'($urandom_range(7));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_value(input logic [31:0] value);
        while (tx_idle_on && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        queue_conversion(value);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [APB_ADDR_WIDTH-1:0] addr,
                                  input logic [APB_DATA_WIDTH-1:0] data);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == RADIX_ADDR) begin
            radix_setting = data[RADIX_BITS-1:0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_decimal_at_reset();
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd123456789);
    endtask

    task automatic test_radix_bounds();
        write_register(RADIX_ADDR, 32'd2);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd0);
        write_register(RADIX_ADDR, 32'd16);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h0123_CDEF);
        // out-of-range radix values saturate to 2 and 16
        write_register(RADIX_ADDR, 32'd0);
        send_value(32'd5);
        write_register(RADIX_ADDR, 32'd1);
        send_value(32'd6);
        write_register(RADIX_ADDR, 32'd31);
        send_value(32'd255);
        write_register(RADIX_ADDR, 32'hFFFF_FFF1);
        send_value(32'hFFFF_FFFE);
    endtask

    task automatic test_unmapped_register();
        write_register(RADIX_ADDR, 32'd8);
        write_register(UNMAPPED_ADDR, 32'd3);
        send_value(32'd64);
    endtask

    task automatic test_output_backpressure();
        write_register(RADIX_ADDR, 32'd10);
        rx_hold_req = 1'b1;
        repeat (4) send_value(random_value());
        wait_drained();
    endtask

    task automatic test_random_values();
        logic [RADIX_BITS-1:0] radix_pick;

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: radix_pick = 5'd10;
                1: radix_pick = 5'd2;
                2: radix_pick = 5'd16;
                default: radix_pick = 5'($urandom_range(31));
            endcase
            write_register(RADIX_ADDR,
                           {(APB_DATA_WIDTH-RADIX_BITS)'($urandom() >> RADIX_BITS),
                            radix_pick});
            // one phase runs with both sides at full rate
            tx_idle_on = (phase != 3);
            rx_idle_on = (phase != 3);
            repeat (PHASE_ITEMS) send_value(random_value());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always begin
        @(negedge aclk);
        if (rx_hold_req) begin
            m_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge aclk);
            rx_hold_req = 1'b0;
        end
        m_tready <= rx_idle_on ? ($urandom_range(99) >= 33) : 1'b1;
    end

    always @(posedge aclk) begin : check_chars
        ascii_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected transfer", 8'h00, m_tdata);
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata[CHAR_BITS-1:0] !== want.character) begin
                    report_mismatch("character", {1'b0, want.character}, m_tdata);
                end
                if (m_tdata[M_TDATA_WIDTH-1] !== 1'b0) begin
                    report_mismatch("tdata pad bit", 8'h00, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last", 8'(want.last), 8'(m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_decimal_at_reset();
        test_radix_bounds();
        test_unmapped_register();
        test_output_backpressure();
        test_random_values();

        wait_drained();
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
